// ===== rtl/ovle_pkg.sv =====
// Shared constants and controller/datapath interface types for the ordered value list engine.
`default_nettype none
package ovle_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = 5;
    localparam int VAL_W = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic load;
        logic rd;
        logic shift_init;
        logic shift;
        logic append;
        logic clear;
        logic dec;
        logic res_load;
        logic res_found;
        logic res_rej;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic ptr_end;
        logic pend_valid;
        logic full;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/ovle_datapath.sv =====
// Datapath of the list engine: entry memory, count, scan pointer and result registers.
`default_nettype none
module ovle_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ovle_pkg::cmd_t                 cmd,
    output ovle_pkg::status_t                   st,
    input  wire logic signed [ovle_pkg::VAL_W-1:0] value,
    output logic                                found,
    output logic [ovle_pkg::LEN_W-1:0]          length,
    output logic                                empty_res,
    output logic                                rejected
);
    import ovle_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;
    logic [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             rd_issue;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             shift_wr;

    assign st.ptr_end    = (ptr_reg >= count_reg);
    assign st.pend_valid = pend_valid_reg;
    assign st.match      = pend_valid_reg && (rdata_reg == value_reg);
    assign st.full       = (count_reg >= CNT_W'(DEPTH));

    assign rd_issue = (cmd.rd || cmd.shift) && !st.ptr_end;
    assign shift_wr = cmd.shift && pend_valid_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = $unsigned(value);
        if (cmd.append)
        begin
            wr_en = 1'b1;
        end
        else if (shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg - IDX_W'(1);
            wr_data = rdata_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        if (cmd.load)
        begin
            ptr_next        = '0;
            pend_valid_next = 1'b0;
        end
        else if (cmd.shift_init)
        begin
            ptr_next        = CNT_W'(pend_idx_reg) + CNT_W'(1);
            pend_valid_next = 1'b0;
        end
        else if (cmd.rd || cmd.shift)
        begin
            pend_valid_next = rd_issue;
            pend_idx_next   = ptr_reg[IDX_W-1:0];
            if (rd_issue)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (cmd.load)
        begin
            value_reg <= $unsigned(value);
        end
        if (cmd.res_load)
        begin
            found     <= cmd.res_found;
            rejected  <= cmd.res_rej;
            length    <= LEN_W'(count_reg);
            empty_res <= (count_reg == '0);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the list depth.");
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !st.full)
        else $error("Append issued on a full list.");
    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        shift_wr |-> (pend_idx_reg != '0))
        else $error("Shift write would target below the first entry.");
    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec |-> (count_reg != '0) && !pend_valid_reg)
        else $error("Remove completed on an empty list or with a shift pending.");
`endif

endmodule
`default_nettype wire

// ===== rtl/ovle_ctrl.sv =====
// Controller state machine that sequences append, clear, scan and shift steps.
`default_nettype none
module ovle_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ovle_pkg::cmd_t         cmd,
    input  wire ovle_pkg::status_t st
);
    import ovle_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       remove_reg, remove_next;
    logic       found_reg, found_next;
    logic       rej_reg, rej_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        remove_next    = remove_reg;
        found_next     = found_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    found_next  = 1'b0;
                    rej_next    = 1'b0;
                    remove_next = (func == OP_REMOVE);
                    case (func)
                        OP_APPEND:
                        begin
                            if (st.full)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (st.match)
                begin
                    if (remove_reg)
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        found_next = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (st.ptr_end && !st.pend_valid)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (st.ptr_end && !st.pend_valid)
                begin
                    cmd.dec    = 1'b1;
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_found  = found_reg;
                    cmd.res_rej    = rej_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            remove_reg    <= 1'b0;
            found_reg     <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remove_reg    <= remove_next;
            found_reg     <= found_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ordered_value_list_engine_unit.sv =====
// Append and clear pass from the idle state straight to the done state, which loads the result
// register once the output register is free or being read. Search and remove walk the entry
// memory in the scan state, one entry per cycle, and a remove that finds a match then shifts the
// tail down in the shift state. One transaction is in progress at a time.
// A new transaction is accepted while the previous result still waits in the output register.
// Reset clears the count and the handshake state; stored entries are not cleared.
`default_nettype none
module ordered_value_list_engine_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        func,
    input  wire logic signed [ovle_pkg::VAL_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   found,
    output logic [ovle_pkg::LEN_W-1:0]             length,
    output logic                                   empty_res,
    output logic                                   rejected
);
    import ovle_pkg::*;

    cmd_t    cmd;
    status_t st;

    ovle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    ovle_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .value     (value),
        .found     (found),
        .length    (length),
        .empty_res (empty_res),
        .rejected  (rejected)
    );

endmodule
`default_nettype wire
